FILE: hdl/varint_length_prefix_deframer_defines.svh
// assertion macros shared by the deframer modules
// both expect aclk and aresetn in the scope of the module that uses them
`ifndef VARINT_LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define VARINT_LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// condition holds in the same cycle
`define VLPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define VLPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/vlpd_pkg.sv
package vlpd_pkg;

    // field widths
    localparam int CONN_W = 6;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 32;
    localparam int CNT_W  = 3;

    // varint prefix coding
    localparam int                GROUP_BITS       = 7;
    localparam logic [BYTE_W-1:0] GROUP_MASK       = 8'h7F;
    localparam int                MORE_BIT         = 7;
    localparam logic [CNT_W-1:0]  MAX_PREFIX_BYTES = 3'd5;
    localparam logic [CNT_W-1:0]  LAST_PREFIX_CNT  = 3'd4;

    // number of connection ids the input can name
    localparam int CONN_IDS = 2 ** CONN_W;

    // decoupling queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    typedef enum logic [0:0] {
        OP_DATA  = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER_BYTE = 3'd0,
        KIND_HEADER_DONE = 3'd1,
        KIND_PAYLOAD     = 3'd2,
        KIND_OVERLONG    = 3'd3,
        KIND_CLOSED      = 3'd4
    } kind_t;

    // one classified input transfer as it sits in the queue
    typedef struct packed {
        op_t               op;
        logic [CONN_W-1:0] conn_id;
        logic [BYTE_W-1:0] data;
    } item_t;

    // per-connection deframing state
    typedef struct packed {
        logic              in_payload;
        logic [LEN_W-1:0]  acc;
        logic [CNT_W-1:0]  cnt;
        logic [LEN_W-1:0]  remaining;
    } conn_state_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

FILE: hdl/varint_length_prefix_deframer.sv
// Varint length-prefix deframer for up to CONNECTIONS byte streams (ids at or
// above CONNECTIONS are dropped with no result). Every other transfer gives
// exactly one result: header byte, header done with the decoded length,
// payload byte with a last-of-packet mark, overlong header error, or closed.
// Sustained rate is one transfer per cycle while m_ready holds; a transfer
// passes the queue, execute stage and result register before its result. The
// rate is set by the per-connection state read-modify-write, whose write-back
// is bypassed to a following transfer on the same connection. A four-entry
// queue between the input side and the state update lets each side stall
// independently. All state is clear right after reset, with no clearing pass.
module varint_length_prefix_deframer
    import vlpd_pkg::*;
#(
    parameter int CONNECTIONS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [CONN_W-1:0] s_conn_id,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CONN_W-1:0] m_conn_id_out,
    output logic [KIND_W-1:0] m_kind,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic              m_last_of_packet,
    output logic [LEN_W-1:0]  m_packet_length
);

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    item_t     push_item;
    item_t     head_item;

    // input side: accept and classify
    vlpd_front #(
        .CONNECTIONS (CONNECTIONS)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_conn_id   (s_conn_id),
        .s_data_byte (s_data_byte),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // decoupling queue
    vlpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    // state update and result register
    vlpd_back #(
        .CONNECTIONS (CONNECTIONS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .q_item           (head_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_conn_id_out    (m_conn_id_out),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_packet (m_last_of_packet),
        .m_packet_length  (m_packet_length)
    );

endmodule

FILE: hdl/vlpd_front.sv
module vlpd_front
    import vlpd_pkg::*;
#(
    parameter int CONNECTIONS = 64
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [CONN_W-1:0] s_conn_id,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  q_status_t         q_status,
    output logic              q_push,
    output item_t             q_item
);

    logic in_range;

    // accept whenever the queue has room
    assign s_ready = !q_status.full;

    // ids beyond the configured connection count are dropped
    assign in_range = 32'(s_conn_id) < 32'(CONNECTIONS);

    assign q_push = s_valid && s_ready && in_range;

    // close transfers carry no byte
    always_comb begin
        q_item.op      = op_t'(s_op);
        q_item.conn_id = s_conn_id;
        q_item.data    = (op_t'(s_op) == OP_CLOSE) ? '0 : s_data_byte;
    end

endmodule

FILE: hdl/vlpd_fifo.sv
`include "varint_length_prefix_deframer_defines.svh"

module vlpd_fifo
    import vlpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head_item,
    output q_status_t status
);

    item_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item        = slot_reg[rd_ptr_reg];
    assign status.full      = count_reg == QCNT_W'(QDEPTH);
    assign status.not_empty = count_reg != '0;

    `VLPD_ASSERT_IMP(a_no_overflow, push, !status.full, "queue written while full")
    `VLPD_ASSERT_IMP(a_no_underflow, pop, status.not_empty, "queue read while empty")
    `VLPD_ASSERT_IMP(a_count_range, 1'b1, count_reg <= QCNT_W'(QDEPTH), "count out of range")

endmodule

FILE: hdl/vlpd_back.sv
`include "varint_length_prefix_deframer_defines.svh"

module vlpd_back
    import vlpd_pkg::*;
#(
    parameter int CONNECTIONS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  q_status_t         q_status,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CONN_W-1:0] m_conn_id_out,
    output logic [KIND_W-1:0] m_kind,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic              m_last_of_packet,
    output logic [LEN_W-1:0]  m_packet_length
);

    localparam int DEPTH = (CONNECTIONS < CONN_IDS) ? CONNECTIONS : CONN_IDS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // state memory with one valid bit per entry; invalid entries read as zero
    conn_state_t        state_mem_reg [DEPTH];
    logic [DEPTH-1:0]   valid_reg;

    // execute stage
    logic               b_valid_reg;
    logic               b_valid_next;
    item_t              b_item_reg;
    conn_state_t        rd_data_reg;
    logic               rd_valid_reg;
    logic               fwd_hit_reg;
    conn_state_t        fwd_data_reg;

    // result register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [CONN_W-1:0]  m_conn_reg;
    kind_t              m_kind_reg;
    logic [BYTE_W-1:0]  m_byte_reg;
    logic               m_last_reg;
    logic [LEN_W-1:0]   m_len_reg;

    logic [IDX_W-1:0]   head_idx;
    logic [IDX_W-1:0]   b_idx;
    logic               b_adv;
    conn_state_t        st_cur;
    conn_state_t        st_next;
    kind_t              res_kind;
    logic [BYTE_W-1:0]  res_byte;
    logic               res_last;
    logic [LEN_W-1:0]   res_len;
    logic [CNT_W-1:0]   cnt_sat;
    logic [5:0]         shamt;
    logic [LEN_W-1:0]   group_shifted;
    logic [LEN_W-1:0]   acc_new;
    logic [LEN_W-1:0]   left;
    logic [CNT_W-1:0]   cnt_inc;

    // conditions watched by the checks
    logic               payload_step;
    logic               rem_zero;
    logic               hdr_done_out;
    logic               len_zero;
    logic               same_conn_load;

    assign head_idx = q_item.conn_id[IDX_W-1:0];
    assign b_idx    = b_item_reg.conn_id[IDX_W-1:0];

    // handshakes between queue, execute stage and result register
    assign b_adv        = b_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop        = q_status.not_empty && (!b_valid_reg || b_adv);
    assign b_valid_next = q_pop ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
    assign m_valid_next = b_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
            if (b_adv) begin
                valid_reg[b_idx] <= 1'b1;
            end
        end
    end

    // state read on entry, write-back on completion
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            state_mem_reg[b_idx] <= st_next;
        end
        if (q_pop) begin
            b_item_reg   <= q_item;
            rd_data_reg  <= state_mem_reg[head_idx];
            rd_valid_reg <= valid_reg[head_idx];
            fwd_hit_reg  <= b_adv && (b_idx == head_idx);
            fwd_data_reg <= st_next;
        end
    end

    // bypass the write-back of the previous transfer to the same connection
    always_comb begin
        if (fwd_hit_reg) begin
            st_cur = fwd_data_reg;
        end else if (rd_valid_reg) begin
            st_cur = rd_data_reg;
        end else begin
            st_cur = '0;
        end
    end

    // prefix group placement
    always_comb begin
        cnt_sat       = (st_cur.cnt > LAST_PREFIX_CNT) ? LAST_PREFIX_CNT : st_cur.cnt;
        shamt         = 6'(cnt_sat) * 6'(GROUP_BITS);
        group_shifted = LEN_W'(b_item_reg.data & GROUP_MASK) << shamt;
        acc_new       = st_cur.acc | group_shifted;
        cnt_inc       = cnt_sat + 1'b1;
        left          = st_cur.remaining - 1'b1;
    end

    // per-connection deframing step
    always_comb begin
        st_next  = st_cur;
        res_kind = KIND_HEADER_BYTE;
        res_byte = '0;
        res_last = 1'b0;
        res_len  = '0;
        if (b_item_reg.op == OP_CLOSE) begin
            st_next  = '0;
            res_kind = KIND_CLOSED;
        end else if (st_cur.in_payload) begin
            st_next.remaining  = left;
            st_next.in_payload = left != '0;
            res_kind           = KIND_PAYLOAD;
            res_byte           = b_item_reg.data;
            res_last           = left == '0;
        end else if (!b_item_reg.data[MORE_BIT]) begin
            // final prefix byte
            st_next.acc = '0;
            st_next.cnt = '0;
            res_kind    = KIND_HEADER_DONE;
            if (acc_new == '0) begin
                res_last = 1'b1;
            end else begin
                st_next.in_payload = 1'b1;
                st_next.remaining  = acc_new;
                res_len            = acc_new;
            end
        end else if (cnt_inc >= MAX_PREFIX_BYTES) begin
            // prefix too long, restart decoding
            st_next.acc = '0;
            st_next.cnt = '0;
            res_kind    = KIND_OVERLONG;
        end else begin
            st_next.acc = acc_new;
            st_next.cnt = cnt_inc;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_conn_reg <= b_item_reg.conn_id;
            m_kind_reg <= res_kind;
            m_byte_reg <= res_byte;
            m_last_reg <= res_last;
            m_len_reg  <= res_len;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_conn_id_out    = m_conn_reg;
    assign m_kind           = m_kind_reg;
    assign m_payload_byte   = m_byte_reg;
    assign m_last_of_packet = m_last_reg;
    assign m_packet_length  = m_len_reg;

    assign payload_step   = b_adv && b_item_reg.op == OP_DATA && st_cur.in_payload;
    assign rem_zero       = st_cur.remaining == '0;
    assign hdr_done_out   = m_valid_reg && m_kind_reg == KIND_HEADER_DONE;
    assign len_zero       = m_len_reg == '0;
    assign same_conn_load = q_pop && b_adv && b_idx == head_idx;

    `VLPD_ASSERT_IMP(a_payload_count_live, payload_step, !rem_zero, "payload with none left")
    `VLPD_ASSERT_IMP(a_zero_len_last, hdr_done_out, m_last_reg == len_zero, "bad last mark")
    `VLPD_ASSERT_NXT(a_fwd_on_load, same_conn_load, fwd_hit_reg, "load not bypassed")

endmodule

FILE: test/tb_varint_length_prefix_deframer.sv
`timescale 1ns / 1ps

module tb_varint_length_prefix_deframer;
    import vlpd_pkg::*;

    localparam int RANDOM_ITEMS = 1180;
    localparam int MAX_WAIT     = 12;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_AT      = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    // one result as the block should present it
    typedef struct {
        logic [CONN_W-1:0] conn;
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              eop;
        logic [LEN_W-1:0]  length;
    } deframe_result_t;

    // one row of the directed stimulus
    typedef struct {
        op_t               op;
        logic [CONN_W-1:0] conn;
        logic [BYTE_W-1:0] data;
        bit                typed;
        kind_t             kind;
        logic              eop;
        logic [LEN_W-1:0]  length;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_op = 1'b0;
    logic [CONN_W-1:0] s_conn_id = '0;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CONN_W-1:0] m_conn_id_out;
    logic [KIND_W-1:0] m_kind;
    logic [BYTE_W-1:0] m_payload_byte;
    logic              m_last_of_packet;
    logic [LEN_W-1:0]  m_packet_length;

    // per-connection deframing state of the predictor
    logic              conn_in_body    [CONN_IDS];
    logic [LEN_W-1:0]  conn_len_acc    [CONN_IDS];
    logic [CNT_W-1:0]  conn_prefix_cnt [CONN_IDS];
    logic [LEN_W-1:0]  conn_left       [CONN_IDS];

    // prefix bytes planned for the next packet of each connection
    logic [BYTE_W-1:0] plan_bytes [CONN_IDS][5];
    int                plan_len   [CONN_IDS];
    int                plan_pos   [CONN_IDS];

    deframe_result_t pending_results[$];
    stim_row_t       stim_rows[$];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              results_seen = 0;
    bit              stim_done = 0;
    bit              send_quiet = 0;
    bit              recv_quiet = 0;

    varint_length_prefix_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_conn_id        (s_conn_id),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_conn_id_out    (m_conn_id_out),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_packet (m_last_of_packet),
        .m_packet_length  (m_packet_length)
    );

    always #2 aclk = ~aclk;

    // run-length watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, what, got, want);
    endtask

    // advance one connection by one transfer and give the result it causes
    function automatic deframe_result_t deframe_byte(input op_t op,
                                                     input logic [CONN_W-1:0] c,
                                                     input logic [BYTE_W-1:0] b);
        deframe_result_t r;
        logic [LEN_W-1:0] acc;
        logic [LEN_W-1:0] left;
        int cnt;
        r.conn   = c;
        r.kind   = KIND_CLOSED;
        r.data   = '0;
        r.eop    = 1'b0;
        r.length = '0;
        if (op == OP_CLOSE) begin
            conn_in_body[c]    = 1'b0;
            conn_len_acc[c]    = '0;
            conn_prefix_cnt[c] = '0;
            conn_left[c]       = '0;
            return r;
        end
        // payload byte
        if (conn_in_body[c]) begin
            left = conn_left[c] - 1;
            conn_left[c] = left;
            if (left == 0)
                conn_in_body[c] = 1'b0;
            r.kind = KIND_PAYLOAD;
            r.data = b;
            r.eop  = (left == 0);
            return r;
        end
        // prefix byte; a fifth group lands at bit 28 and wraps
        cnt = int'(conn_prefix_cnt[c]);
        if (cnt > LAST_PREFIX_CNT)
            cnt = int'(LAST_PREFIX_CNT);
        acc = conn_len_acc[c] | ({25'd0, b[6:0]} << (cnt * GROUP_BITS));
        if (!b[MORE_BIT]) begin
            conn_len_acc[c]    = '0;
            conn_prefix_cnt[c] = '0;
            r.kind = KIND_HEADER_DONE;
            if (acc == 0) begin
                r.eop = 1'b1;
            end else begin
                conn_in_body[c] = 1'b1;
                conn_left[c]    = acc;
                r.length        = acc;
            end
            return r;
        end
        cnt++;
        if (cnt >= MAX_PREFIX_BYTES) begin
            conn_len_acc[c]    = '0;
            conn_prefix_cnt[c] = '0;
            r.kind = KIND_OVERLONG;
            return r;
        end
        conn_len_acc[c]    = acc;
        conn_prefix_cnt[c] = CNT_W'(cnt);
        r.kind = KIND_HEADER_BYTE;
        return r;
    endfunction

    // choose the prefix of the next packet on a connection
    function automatic void plan_prefix(input logic [CONN_W-1:0] c);
        logic [LEN_W-1:0] length;
        int roll;
        int n;
        int m;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            length = $urandom_range(0, 8);
        else if (roll < 75)
            length = $urandom_range(9, 100);
        else
            length = $urandom >> $urandom_range(0, 31);
        // minimal encoding, low group first
        n = 0;
        do begin
            plan_bytes[c][n] = {1'b0, length[6:0]};
            length = length >> GROUP_BITS;
            if (length != 0)
                plan_bytes[c][n][MORE_BIT] = 1'b1;
            n++;
        end while (length != 0);
        roll = $urandom_range(0, 99);
        if (roll < 10 && n < 5) begin
            // non-minimal: padded with empty groups
            m = $urandom_range(n + 1, 5);
            plan_bytes[c][n - 1][MORE_BIT] = 1'b1;
            for (int i = n; i < m - 1; i++)
                plan_bytes[c][i] = 8'h80;
            plan_bytes[c][m - 1] = 8'h00;
            n = m;
        end else if (roll < 18) begin
            // overlong: continuation on all five
            n = 5;
            for (int i = 0; i < 5; i++)
                plan_bytes[c][i] = 8'($urandom) | 8'h80;
        end else if (roll < 25) begin
            // random groups, fifth group may wrap
            n = $urandom_range(1, 5);
            for (int i = 0; i < n - 1; i++)
                plan_bytes[c][i] = 8'($urandom) | 8'h80;
            plan_bytes[c][n - 1] = 8'($urandom) & GROUP_MASK;
        end
        plan_len[c] = n;
        plan_pos[c] = 0;
    endfunction

    // mostly well-formed packets on a few connections, some noise and closes
    function automatic void pick_random_item(output op_t op,
                                             output logic [CONN_W-1:0] c,
                                             output logic [BYTE_W-1:0] b);
        int roll;
        roll = $urandom_range(0, 99);
        c = ($urandom_range(0, 99) < 85) ? CONN_W'($urandom_range(0, 3))
                                         : CONN_W'($urandom_range(0, CONN_IDS - 1));
        b = 8'($urandom);
        op = OP_DATA;
        if (roll < 5) begin
            op = op_t'($urandom_range(0, 1));
            return;
        end
        if (conn_in_body[c]) begin
            // long packets are cut short by a close
            if ((conn_left[c] > 100) ? (roll < 20) : (roll < 7)) begin
                op = OP_CLOSE;
                plan_pos[c] = plan_len[c];
            end
            return;
        end
        if (roll < 8) begin
            op = OP_CLOSE;
            plan_pos[c] = plan_len[c];
            return;
        end
        if (plan_pos[c] >= plan_len[c])
            plan_prefix(c);
        b = plan_bytes[c][plan_pos[c]];
        plan_pos[c]++;
    endfunction

    function automatic void add_row(input op_t op, input logic [CONN_W-1:0] c,
                                    input logic [BYTE_W-1:0] b, input bit typed = 0,
                                    input kind_t k = KIND_HEADER_BYTE,
                                    input logic eop = 1'b0,
                                    input logic [LEN_W-1:0] length = '0);
        stim_row_t row;
        row.op     = op;
        row.conn   = c;
        row.data   = b;
        row.typed  = typed;
        row.kind   = k;
        row.eop    = eop;
        row.length = length;
        stim_rows.push_back(row);
    endfunction

    // reset and end of run
    initial begin
        for (int i = 0; i < CONN_IDS; i++) begin
            conn_in_body[i]    = 1'b0;
            conn_len_acc[i]    = '0;
            conn_prefix_cnt[i] = '0;
            conn_left[i]       = '0;
            plan_len[i]        = 0;
            plan_pos[i]        = 0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // input side: directed rows, then random transfers
    initial begin : sender
        op_t               op;
        logic [CONN_W-1:0] c;
        logic [BYTE_W-1:0] b;
        deframe_result_t   r;
        int                gap;
        int                n_rows;

        // zero length completes at once
        add_row(OP_DATA, 6'd0, 8'h00, 1, KIND_HEADER_DONE, 1'b1, 32'd0);
        // short packet, last byte marked
        add_row(OP_DATA, 6'd1, 8'h03, 1, KIND_HEADER_DONE, 1'b0, 32'd3);
        add_row(OP_DATA, 6'd1, 8'hFF);
        add_row(OP_DATA, 6'd1, 8'h00);
        add_row(OP_DATA, 6'd1, 8'hA5);
        // five continuation bytes: overlong header
        add_row(OP_DATA, 6'd2, 8'h80, 1, KIND_HEADER_BYTE);
        add_row(OP_DATA, 6'd2, 8'h80, 1, KIND_HEADER_BYTE);
        add_row(OP_DATA, 6'd2, 8'h80, 1, KIND_HEADER_BYTE);
        add_row(OP_DATA, 6'd2, 8'h80, 1, KIND_HEADER_BYTE);
        add_row(OP_DATA, 6'd2, 8'h80, 1, KIND_OVERLONG);
        // largest length, fifth group wraps, then close mid-payload
        add_row(OP_DATA, 6'd3, 8'hFF);
        add_row(OP_DATA, 6'd3, 8'hFF);
        add_row(OP_DATA, 6'd3, 8'hFF);
        add_row(OP_DATA, 6'd3, 8'hFF);
        add_row(OP_DATA, 6'd3, 8'h7F, 1, KIND_HEADER_DONE, 1'b0, 32'hFFFF_FFFF);
        add_row(OP_CLOSE, 6'd3, 8'h00, 1, KIND_CLOSED);
        // close in the middle of a prefix, then a fresh packet
        add_row(OP_DATA, 6'd63, 8'h81);
        add_row(OP_CLOSE, 6'd63, 8'hFF, 1, KIND_CLOSED);
        add_row(OP_DATA, 6'd63, 8'h01);
        add_row(OP_DATA, 6'd63, 8'h5A);
        // close of an idle connection
        add_row(OP_CLOSE, 6'd0, 8'hFF, 1, KIND_CLOSED);
        n_rows = stim_rows.size();

        wait (aresetn);
        for (int idx = 0; idx < n_rows + RANDOM_ITEMS; idx++) begin
            if (idx < n_rows) begin
                op = stim_rows[idx].op;
                c  = stim_rows[idx].conn;
                b  = stim_rows[idx].data;
            end else begin
                pick_random_item(op, c, b);
            end
            if ($urandom_range(0, 39) == 0)
                send_quiet = !send_quiet;
            gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge aclk);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid     <= 1'b1;
            s_op        <= op;
            s_conn_id   <= c;
            s_data_byte <= b;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            // transfer accepted: predict its result
            r = deframe_byte(op, c, b);
            if (idx < n_rows && stim_rows[idx].typed) begin
                r.conn   = c;
                r.kind   = stim_rows[idx].kind;
                r.data   = '0;
                r.eop    = stim_rows[idx].eop;
                r.length = stim_rows[idx].length;
            end
            pending_results.push_back(r);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // output side: random stalls, one long hold, field checks
    initial begin : receiver
        deframe_result_t want;
        int              hold;

        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            hold = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (results_seen == HOLD_AT)
                hold = LONG_HOLD;
            if (hold > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", 32'(m_kind), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_conn_id_out !== want.conn)
                    report_mismatch("conn_id_out", 32'(m_conn_id_out), 32'(want.conn));
                if (m_kind !== want.kind)
                    report_mismatch("kind", 32'(m_kind), 32'(want.kind));
                if (m_payload_byte !== want.data)
                    report_mismatch("payload_byte", 32'(m_payload_byte), 32'(want.data));
                if (m_last_of_packet !== want.eop)
                    report_mismatch("last_of_packet", 32'(m_last_of_packet), 32'(want.eop));
                if (m_packet_length !== want.length)
                    report_mismatch("packet_length", m_packet_length, want.length);
            end
        end
    end

endmodule
